/* sv/pbwf_pkg.sv */
// Shared types, codes and the varint shift helper function of the protobuf wire field parser.
package pbwf_pkg;

  // Default width of the largest accepted length-delimited length.
  localparam int LENGTH_BITS_DEF = 16;

  // Varint and fixed-width field sizes in bytes.
  localparam int VARINT_MAX_BYTES = 10;
  localparam int FIX64_BYTES      = 8;
  localparam int FIX32_BYTES      = 4;

  // Depth of the result queue; room for two results is needed to take an item.
  localparam int QUEUE_DEPTH = 4;

  // Wire types that the parser understands.
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  // Result kinds.
  localparam logic [2:0] KIND_VARINT   = 3'd0;
  localparam logic [2:0] KIND_FIX64    = 3'd1;
  localparam logic [2:0] KIND_BYTES_HD = 3'd2;
  localparam logic [2:0] KIND_BYTES_DT = 3'd3;
  localparam logic [2:0] KIND_FIX32    = 3'd4;
  localparam logic [2:0] KIND_MSG_END  = 3'd5;

  // Message status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNCATED = 3'd1;
  localparam logic [2:0] ST_BAD_WIRE  = 3'd2;
  localparam logic [2:0] ST_VARINT_LONG = 3'd3;
  localparam logic [2:0] ST_LEN_LARGE = 3'd4;

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic [2:0]  status;
    logic        eom;
  } res_t;

  // Results produced by one accepted item: count, then up to two in order.
  typedef struct packed {
    logic [1:0] n;
    res_t       first;
    res_t       second;
  } push_t;

  // Bit position of the seven value bits of varint byte number idx.
  function automatic logic [5:0] varint_shift(input logic [3:0] idx);
    logic [5:0] sh;
    begin
      case (idx)
        4'd0:    sh = 6'd0;
        4'd1:    sh = 6'd7;
        4'd2:    sh = 6'd14;
        4'd3:    sh = 6'd21;
        4'd4:    sh = 6'd28;
        4'd5:    sh = 6'd35;
        4'd6:    sh = 6'd42;
        4'd7:    sh = 6'd49;
        4'd8:    sh = 6'd56;
        4'd9:    sh = 6'd63;
        default: sh = 6'd0;
      endcase
      return sh;
    end
  endfunction

endpackage

/* sv/protobuf_wire_field_parser.sv */
// Top level of the protobuf wire field parser: decoder and result queue.
//
// Usage: payload bytes enter on the input channel (in_valid, in_ready,
// payload_byte, last_byte), one byte per item, with last_byte set on the
// final byte of a message. Results leave on the output channel (out_valid,
// out_ready and the result fields), one result item per transfer.
// A byte is decoded in the cycle it is accepted, and its results are
// written into the result queue. One byte is accepted every cycle while the
// receiver keeps up. A final byte that also completes a field causes two
// results, which leave as two separate transfers.
// Results wait in a four-entry queue; in_ready drops whenever fewer than
// two entries are free, so with a stalled receiver the input stops once
// three or more results are waiting, and nothing is lost.
// Reset empties the queue and puts the parser in its tag state. After the
// final byte the parser returns to that state by itself, ready for the next
// message. Errors are sticky within a message and reported in the status
// of the message end result.
module protobuf_wire_field_parser #(
  parameter int LENGTH_BITS = pbwf_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  payload_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [31:0] field_number,
  output logic [2:0]  wire_type,
  output logic [63:0] field_value,
  output logic [2:0]  status,
  output logic        end_of_message
);
  import pbwf_pkg::*;

  push_t push;
  res_t  head;
  logic  room;
  logic  take;

  assign in_ready = room;
  assign take     = in_valid && room;

  // Byte decoder.
  pbwf_decode #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .push         (push)
  );

  // Output queue.
  pbwf_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Result fields onto the ports.
  assign result_kind    = head.kind;
  assign field_number   = head.field_number;
  assign wire_type      = head.wire_type;
  assign field_value    = head.value;
  assign status         = head.status;
  assign end_of_message = head.eom;

endmodule

/* sv/pbwf_decode.sv */
// Field decoder: parse state registers and the per-byte next-state and result logic.
module pbwf_decode #(
  parameter int LENGTH_BITS = pbwf_pkg::LENGTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      payload_byte,
  input  logic            last_byte,
  output pbwf_pkg::push_t push
);
  import pbwf_pkg::*;

  typedef enum logic [6:0] {
    PH_TAG    = 7'b0000001,
    PH_VARINT = 7'b0000010,
    PH_FIX64  = 7'b0000100,
    PH_LEN    = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_FIX32  = 7'b0100000,
    PH_DRAIN  = 7'b1000000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [3:0]             byte_counter, byte_counter_next;
  logic [63:0]            accumulator, accumulator_next;
  logic [31:0]            cur_field_number, cur_field_number_next;
  logic [2:0]             cur_wire_type, cur_wire_type_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [2:0]             sticky_error, sticky_error_next;

  logic [63:0]            var_full;
  logic [63:0]            fix32_full;
  logic [3:0]             cnt_inc;
  logic                   var_done;
  logic                   var_long;
  logic                   field_emit;
  logic [2:0]             field_kind;
  logic [63:0]            field_value;
  logic [2:0]             end_status;
  logic [LENGTH_BITS-1:0] remaining_dec;
  res_t                   field_res;
  res_t                   end_res;

  // Byte merges for varint and little-endian fixed32 accumulation.
  assign var_full   = accumulator |
                      ({57'd0, payload_byte[6:0]} << varint_shift(byte_counter));
  assign fix32_full = accumulator |
                      ({56'd0, payload_byte} << {byte_counter[1:0], 3'b000});
  assign cnt_inc    = byte_counter + 4'd1;
  assign var_done   = !payload_byte[7];
  assign var_long   = payload_byte[7] && (byte_counter == 4'(VARINT_MAX_BYTES - 1));
  assign remaining_dec = remaining - LENGTH_BITS'(1);

  // Next state and field result for one byte.
  always_comb begin
    phase_next            = phase;
    byte_counter_next     = byte_counter;
    accumulator_next      = accumulator;
    cur_field_number_next = cur_field_number;
    cur_wire_type_next    = cur_wire_type;
    remaining_next        = remaining;
    sticky_error_next     = sticky_error;
    field_emit            = 1'b0;
    field_kind            = KIND_VARINT;
    field_value           = 64'd0;
    end_status            = ST_OK;

    case (phase)
      PH_TAG: begin
        if (var_long) begin
          sticky_error_next = ST_VARINT_LONG;
          phase_next        = PH_DRAIN;
        end else if (var_done) begin
          cur_field_number_next = var_full[34:3];
          cur_wire_type_next    = var_full[2:0];
          accumulator_next      = 64'd0;
          byte_counter_next     = 4'd0;
          case (var_full[2:0])
            WT_VARINT: phase_next = PH_VARINT;
            WT_FIX64:  phase_next = PH_FIX64;
            WT_LEN:    phase_next = PH_LEN;
            WT_FIX32:  phase_next = PH_FIX32;
            default: begin
              sticky_error_next = ST_BAD_WIRE;
              phase_next        = PH_DRAIN;
            end
          endcase
        end else begin
          accumulator_next  = var_full;
          byte_counter_next = cnt_inc;
        end
      end
      PH_VARINT: begin
        if (var_long) begin
          sticky_error_next = ST_VARINT_LONG;
          phase_next        = PH_DRAIN;
        end else if (var_done) begin
          field_emit        = 1'b1;
          field_kind        = KIND_VARINT;
          field_value       = var_full;
          phase_next        = PH_TAG;
          byte_counter_next = 4'd0;
          accumulator_next  = 64'd0;
        end else begin
          accumulator_next  = var_full;
          byte_counter_next = cnt_inc;
        end
      end
      PH_LEN: begin
        if (var_long) begin
          sticky_error_next = ST_VARINT_LONG;
          phase_next        = PH_DRAIN;
        end else if (var_done) begin
          if (|var_full[63:LENGTH_BITS]) begin
            sticky_error_next = ST_LEN_LARGE;
            phase_next        = PH_DRAIN;
            accumulator_next  = var_full;
          end else begin
            field_emit        = 1'b1;
            field_kind        = KIND_BYTES_HD;
            field_value       = var_full;
            remaining_next    = var_full[LENGTH_BITS-1:0];
            byte_counter_next = 4'd0;
            accumulator_next  = 64'd0;
            phase_next        = (|var_full[LENGTH_BITS-1:0]) ? PH_DATA : PH_TAG;
          end
        end else begin
          accumulator_next  = var_full;
          byte_counter_next = cnt_inc;
        end
      end
      PH_DATA: begin
        field_emit     = 1'b1;
        field_kind     = KIND_BYTES_DT;
        field_value    = {56'd0, payload_byte};
        remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          phase_next        = PH_TAG;
          byte_counter_next = 4'd0;
          accumulator_next  = 64'd0;
        end
      end
      PH_FIX64: begin
        byte_counter_next = cnt_inc;
        if (cnt_inc >= 4'(FIX64_BYTES)) begin
          field_emit        = 1'b1;
          field_kind        = KIND_FIX64;
          field_value       = 64'd0;
          phase_next        = PH_TAG;
          byte_counter_next = 4'd0;
          accumulator_next  = 64'd0;
        end
      end
      PH_FIX32: begin
        accumulator_next  = fix32_full;
        byte_counter_next = cnt_inc;
        if (cnt_inc >= 4'(FIX32_BYTES)) begin
          field_emit        = 1'b1;
          field_kind        = KIND_FIX32;
          field_value       = {32'd0, fix32_full[31:0]};
          phase_next        = PH_TAG;
          byte_counter_next = 4'd0;
          accumulator_next  = 64'd0;
        end
      end
      default: begin
        // Draining after an error: bytes are consumed without results.
      end
    endcase

    // The final byte closes the message and returns to the reset state.
    if (last_byte) begin
      end_status = sticky_error_next;
      if (end_status == ST_OK &&
          (phase_next != PH_TAG || byte_counter_next != 4'd0)) begin
        end_status = ST_TRUNCATED;
      end
      phase_next            = PH_TAG;
      byte_counter_next     = 4'd0;
      accumulator_next      = 64'd0;
      cur_field_number_next = 32'd0;
      cur_wire_type_next    = 3'd0;
      remaining_next        = '0;
      sticky_error_next     = ST_OK;
    end
  end

  // Result items for the queue, field result first.
  always_comb begin
    field_res.kind         = field_kind;
    field_res.field_number = cur_field_number;
    field_res.wire_type    = cur_wire_type;
    field_res.value        = field_value;
    field_res.status       = ST_OK;
    field_res.eom          = 1'b0;

    end_res.kind           = KIND_MSG_END;
    end_res.field_number   = 32'd0;
    end_res.wire_type      = 3'd0;
    end_res.value          = 64'd0;
    end_res.status         = end_status;
    end_res.eom            = 1'b1;

    push.n      = take ? (2'(field_emit) + 2'(last_byte)) : 2'd0;
    push.first  = field_emit ? field_res : end_res;
    push.second = end_res;
  end

  // Parse state registers, updated on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_TAG;
      byte_counter     <= 4'd0;
      accumulator      <= 64'd0;
      cur_field_number <= 32'd0;
      cur_wire_type    <= 3'd0;
      remaining        <= '0;
      sticky_error     <= ST_OK;
    end else if (take) begin
      phase            <= phase_next;
      byte_counter     <= byte_counter_next;
      accumulator      <= accumulator_next;
      cur_field_number <= cur_field_number_next;
      cur_wire_type    <= cur_wire_type_next;
      remaining        <= remaining_next;
      sticky_error     <= sticky_error_next;
    end
  end

  // A closed message leaves the parser clean for the next one.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    take && last_byte |=> phase == PH_TAG && sticky_error == ST_OK && byte_counter == 4'd0)
    else $error("parser state not cleared after the final byte");

  // A raised error always parks the parser in the drain phase.
  a_error_drains: assert property (@(posedge clk) disable iff (rst)
    sticky_error != ST_OK |-> phase == PH_DRAIN)
    else $error("sticky error without drain phase");

  // The data phase always has at least one byte left to take.
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> remaining != '0)
    else $error("data phase with no bytes remaining");

endmodule

/* sv/pbwf_result_queue.sv */
// Result queue: holds decoded result items until the receiver takes them.
module pbwf_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  pbwf_pkg::push_t  push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output pbwf_pkg::res_t   head
);
  import pbwf_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  res_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wptr, wptr_next;
  logic [PTR_BITS-1:0] rptr;
  logic [CNT_BITS-1:0] count, count_next;
  logic                pop;

  // Room for the two results one item can cause.
  assign room      = count <= CNT_BITS'(QUEUE_DEPTH - 2);
  assign out_valid = count != '0;
  assign head      = entries[rptr];
  assign pop       = out_valid && out_ready;
  assign wptr_next = wptr + PTR_BITS'(1);
  assign count_next = count + CNT_BITS'(push.n) - CNT_BITS'(pop);

  // Entry storage; the second result goes one slot after the first.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      entries[wptr_next] <= push.second;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_BITS'(push.n);
      rptr  <= rptr + PTR_BITS'(pop);
      count <= count_next;
    end
  end

  // The fill count never passes the queue depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // Two results from one item only happen when the second closes the message.
  a_pair_ends: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> push.second.eom && push.second.kind == KIND_MSG_END)
    else $error("paired result without message end");

  // A waiting result item stays put until the receiver takes it.
  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(head))
    else $error("result item changed while waiting");

endmodule

/* test/tb_protobuf_wire_field_parser.sv */
// Testbench for the protobuf wire field parser: random and directed messages checked by a predictor.
`timescale 1ns / 1ps

module tb_protobuf_wire_field_parser;
  import pbwf_pkg::*;

  // Largest length that the parser accepts for a length-delimited field.
  localparam logic [63:0] MAX_LEN = (64'd1 << LENGTH_BITS_DEF) - 64'd1;

  // Wire types that the parser rejects.
  localparam logic [2:0] WT_UNKNOWN [4] = '{3'd3, 3'd4, 3'd6, 3'd7};

  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  // Length of the receiver hold-off in the back-pressure test.
  localparam int HOLD_CYCLES = 240;

  // Cycles to let the pipeline settle once nothing is expected.
  localparam int SETTLE_CYCLES = 5;

  // Parser phases as the predictor tracks them.
  typedef enum logic [2:0] {
    PH_TAG, PH_VARINT, PH_FIX64, PH_LEN, PH_DATA, PH_FIX32, PH_DRAIN
  } parse_phase_t;

  // Outcome of taking one varint byte.
  typedef enum logic [1:0] {VARINT_MORE, VARINT_DONE, VARINT_TOO_LONG} varint_step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  payload_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  result_kind;
  logic [31:0] field_number;
  logic [2:0]  wire_type;
  logic [63:0] field_value;
  logic [2:0]  status;
  logic        end_of_message;

  // Predictor state.
  parse_phase_t dec_phase;
  logic [3:0]   dec_count;
  logic [63:0]  dec_acc;
  logic [31:0]  dec_field;
  logic [2:0]   dec_wtype;
  logic [63:0]  dec_left;
  logic [2:0]   dec_error;

  // Results still owed by the parser, oldest first.
  res_t field_results_due[$];
  res_t oldest_due;

  // Bytes of the message being assembled.
  logic [7:0] msg_bytes[$];

  int mismatch_count = 0;
  int bytes_sent = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  protobuf_wire_field_parser #(.LENGTH_BITS(LENGTH_BITS_DEF)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .payload_byte(payload_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .field_number(field_number),
    .wire_type(wire_type),
    .field_value(field_value),
    .status(status),
    .end_of_message(end_of_message)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor: clears all decoder state, as reset and a message end do.
  function automatic void clear_decoder();
    dec_phase = PH_TAG;
    dec_count = 4'd0;
    dec_acc   = 64'd0;
    dec_field = 32'd0;
    dec_wtype = 3'd0;
    dec_left  = 64'd0;
    dec_error = ST_OK;
  endfunction

  // Appends one owed result at the tail of the expected list.
  function automatic void owe_result(input res_t r);
    field_results_due = {field_results_due, r};
  endfunction

  // Appends one byte to the message being assembled.
  function automatic void append_byte(input logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endfunction

  // Adds one byte to the varint being collected; bits past bit 63 are lost.
  function automatic varint_step_t absorb_varint_byte(input logic [7:0] b);
    int sh;
    sh = 7 * int'(dec_count);
    if (sh < 64)
      dec_acc = dec_acc | (64'(b[6:0]) << sh);
    if (!b[7])
      return VARINT_DONE;
    dec_count = dec_count + 4'd1;
    if (dec_count >= VARINT_MAX_BYTES)
      return VARINT_TOO_LONG;
    return VARINT_MORE;
  endfunction

  function automatic void raise_error(input logic [2:0] code);
    dec_error = code;
    dec_phase = PH_DRAIN;
  endfunction

  function automatic void start_next_field();
    dec_phase = PH_TAG;
    dec_count = 4'd0;
    dec_acc   = 64'd0;
  endfunction

  function automatic void push_field_result(input logic [2:0] kind, input logic [63:0] value);
    res_t r;
    r.kind         = kind;
    r.field_number = dec_field;
    r.wire_type    = dec_wtype;
    r.value        = value;
    r.status       = ST_OK;
    r.eom          = 1'b0;
    owe_result(r);
  endfunction

  // Predictor: works out the results of one accepted byte.
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    varint_step_t step;
    logic [2:0]   st;
    res_t         fin;
    case (dec_phase)
      PH_TAG: begin
        step = absorb_varint_byte(b);
        if (step == VARINT_TOO_LONG) begin
          raise_error(ST_VARINT_LONG);
        end else if (step == VARINT_DONE) begin
          dec_field = dec_acc[34:3];
          dec_wtype = dec_acc[2:0];
          dec_acc   = 64'd0;
          dec_count = 4'd0;
          case (dec_wtype)
            WT_VARINT: dec_phase = PH_VARINT;
            WT_FIX64:  dec_phase = PH_FIX64;
            WT_LEN:    dec_phase = PH_LEN;
            WT_FIX32:  dec_phase = PH_FIX32;
            default:   raise_error(ST_BAD_WIRE);
          endcase
        end
      end
      PH_VARINT: begin
        step = absorb_varint_byte(b);
        if (step == VARINT_TOO_LONG) begin
          raise_error(ST_VARINT_LONG);
        end else if (step == VARINT_DONE) begin
          push_field_result(KIND_VARINT, dec_acc);
          start_next_field();
        end
      end
      PH_LEN: begin
        step = absorb_varint_byte(b);
        if (step == VARINT_TOO_LONG) begin
          raise_error(ST_VARINT_LONG);
        end else if (step == VARINT_DONE) begin
          if (dec_acc > MAX_LEN) begin
            raise_error(ST_LEN_LARGE);
          end else begin
            push_field_result(KIND_BYTES_HD, dec_acc);
            dec_left = dec_acc;
            start_next_field();
            if (dec_left != 64'd0)
              dec_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        push_field_result(KIND_BYTES_DT, {56'd0, b});
        dec_left = (dec_left - 64'd1) & MAX_LEN;
        if (dec_left == 64'd0)
          start_next_field();
      end
      PH_FIX64: begin
        dec_count = dec_count + 4'd1;
        if (dec_count >= FIX64_BYTES) begin
          push_field_result(KIND_FIX64, 64'd0);
          start_next_field();
        end
      end
      PH_FIX32: begin
        dec_acc = dec_acc | (64'(b) << (8 * int'(dec_count[1:0])));
        dec_count = dec_count + 4'd1;
        if (dec_count >= FIX32_BYTES) begin
          push_field_result(KIND_FIX32, {32'd0, dec_acc[31:0]});
          start_next_field();
        end
      end
      default: begin
      end
    endcase

    // The final byte closes the message; an unfinished field means truncation.
    if (last) begin
      st = dec_error;
      if (st == ST_OK && (dec_phase != PH_TAG || dec_count != 4'd0))
        st = ST_TRUNCATED;
      fin.kind         = KIND_MSG_END;
      fin.field_number = 32'd0;
      fin.wire_type    = 3'd0;
      fin.value        = 64'd0;
      fin.status       = st;
      fin.eom          = 1'b1;
      owe_result(fin);
      clear_decoder();
    end
  endfunction

  // Random value of random bit width, now and then all ones.
  function automatic logic [63:0] rand_wide(input int max_bits);
    int w;
    logic [63:0] v;
    w = $urandom_range(0, max_bits);
    v = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0)
      return {64{1'b1}} >> (64 - max_bits);
    if (w == 0)
      return 64'd0;
    return v >> (64 - w);
  endfunction

  function automatic logic [60:0] rand_field_number();
    if ($urandom_range(0, 1) == 0)
      return 61'($urandom_range(0, 31));
    return 61'(rand_wide(61));
  endfunction

  // Extra continuation bytes for a non-minimal varint encoding.
  function automatic int rand_pad();
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(1, 3);
    return 0;
  endfunction

  // Appends a varint, padded with zero groups up to ten bytes at most.
  task automatic add_varint(input logic [63:0] v, input int pad);
    int n;
    int i;
    logic [63:0] rest;
    n = 1;
    rest = v >> 7;
    while (rest != 64'd0) begin
      n++;
      rest = rest >> 7;
    end
    n = n + pad;
    if (n > VARINT_MAX_BYTES)
      n = VARINT_MAX_BYTES;
    rest = v;
    for (i = 0; i < n; i++) begin
      append_byte({i != n - 1, rest[6:0]});
      rest = rest >> 7;
    end
  endtask

  task automatic add_tag(input logic [60:0] fnum, input logic [2:0] wt, input int pad);
    add_varint({fnum, wt}, pad);
  endtask

  task automatic add_random_bytes(input int count);
    repeat (count) append_byte(8'($urandom_range(0, 255)));
  endtask

  // A ten-byte varint, as a tag or as a value: either too long or with junk
  // bits in its tenth byte that fall off the top.
  task automatic add_long_varint();
    int i;
    if ($urandom_range(0, 1) == 0)
      add_tag(rand_field_number(), WT_VARINT, 0);
    for (i = 0; i < VARINT_MAX_BYTES - 1; i++)
      append_byte(8'h80 | 8'($urandom_range(0, 127)));
    if ($urandom_range(0, 1) == 0)
      append_byte(8'h80 | 8'($urandom_range(0, 127)));
    else
      append_byte(8'($urandom_range(0, 127)));
  endtask

  // Mostly well-formed fields with random content, some errors, noise and
  // messages cut short.
  task automatic build_random_message();
    int nfields;
    int k;
    int pick;
    int len;
    logic stop;
    nfields = $urandom_range(1, 6);
    stop = 1'b0;
    for (k = 0; k < nfields && !stop; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        add_tag(rand_field_number(), WT_VARINT, rand_pad());
        add_varint(rand_wide(64), rand_pad());
      end else if (pick < 42) begin
        add_tag(rand_field_number(), WT_FIX32, rand_pad());
        add_random_bytes(FIX32_BYTES);
      end else if (pick < 52) begin
        add_tag(rand_field_number(), WT_FIX64, rand_pad());
        add_random_bytes(FIX64_BYTES);
      end else if (pick < 78) begin
        add_tag(rand_field_number(), WT_LEN, rand_pad());
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        add_varint(64'(len), rand_pad());
        add_random_bytes(len);
      end else if (pick < 81) begin
        // Largest legal length; the message ends well inside its data.
        add_tag(rand_field_number(), WT_LEN, rand_pad());
        add_varint(MAX_LEN, rand_pad());
        add_random_bytes($urandom_range(0, 4));
        stop = 1'b1;
      end else if (pick < 85) begin
        add_tag(rand_field_number(), WT_LEN, rand_pad());
        if ($urandom_range(0, 2) == 0)
          add_varint(MAX_LEN + 64'd1, rand_pad());
        else
          add_varint((MAX_LEN + 64'd1) | rand_wide(64), rand_pad());
        add_random_bytes($urandom_range(0, 3));
        stop = 1'b1;
      end else if (pick < 89) begin
        add_tag(rand_field_number(), WT_UNKNOWN[$urandom_range(0, 3)], rand_pad());
        add_random_bytes($urandom_range(0, 4));
        stop = 1'b1;
      end else if (pick < 95) begin
        add_long_varint();
      end else begin
        add_random_bytes($urandom_range(1, 5));
      end
    end
    // Cut some messages short so that fields are left unfinished.
    if (msg_bytes.size() > 1 && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, msg_bytes.size() - 1)) void'(msg_bytes.pop_back());
  endtask

  // Offers one byte and waits for it to be taken, with a random gap first.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < src_idle_pct)
      gap = $urandom_range(1, 3);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    payload_byte <= b;
    last_byte    <= last;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_message();
    int i;
    for (i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  // Stops offering bytes until every owed result has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (field_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Every result kind, extreme fixed32 bytes and a zero length.
  task automatic test_field_kinds();
    add_tag(1, WT_VARINT, 0);
    add_varint(64'd0, 0);
    add_tag(1, WT_FIX32, 0);
    msg_bytes = {msg_bytes, 8'h00, 8'hFF, 8'h80, 8'h7F};
    add_tag(2, WT_FIX64, 0);
    msg_bytes = {msg_bytes, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
    add_tag(3, WT_LEN, 0);
    add_varint(64'd0, 0);
    add_tag(4, WT_LEN, 0);
    add_varint(64'd1, 0);
    append_byte(8'hFF);
    send_message();
  endtask

  // Errors raised by the final byte itself, and a tag left without a value.
  task automatic test_error_cases();
    add_tag(1, WT_UNKNOWN[0], 0);
    send_message();
    add_tag(1, WT_VARINT, 0);
    send_message();
    add_tag(1, WT_LEN, 0);
    add_varint(MAX_LEN + 64'd1, 0);
    send_message();
  endtask

  task automatic test_random_messages(input int src_pct, input int sink_pct, input int budget);
    int target;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    target = bytes_sent + budget;
    while (bytes_sent < target) begin
      build_random_message();
      send_message();
    end
  endtask

  // The receiver holds off while bytes keep coming, so the input stalls.
  task automatic test_output_backpressure();
    int target;
    hold_trigger++;
    target = bytes_sent + 120;
    while (bytes_sent < target) begin
      build_random_message();
      send_message();
    end
  endtask

  // Receiver: random ready, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Each result item against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (field_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0d value %0h",
                 $time, result_kind, field_value);
        mismatch_count++;
      end else begin
        oldest_due = field_results_due.pop_front();
        compare_field("result_kind", 64'(oldest_due.kind), 64'(result_kind));
        compare_field("field_number", 64'(oldest_due.field_number), 64'(field_number));
        compare_field("wire_type", 64'(oldest_due.wire_type), 64'(wire_type));
        compare_field("field_value", oldest_due.value, field_value);
        compare_field("status", 64'(oldest_due.status), 64'(status));
        compare_field("end_of_message", 64'(oldest_due.eom), 64'(end_of_message));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clear_decoder();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct  = 26;
    sink_idle_pct = 53;
    test_field_kinds();
    test_error_cases();
    test_random_messages(26, 53, 480);
    test_output_backpressure();
    wait_for_drain();
    test_random_messages(53, 26, 480);
    wait_for_drain();
    test_random_messages(0, 0, 430);
    wait_for_drain();

    if (mismatch_count == 0 && field_results_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
